// ----- hdl/differential_drive_steering_top_assert.svh -----
// assertion macros for the checker file dds_checker.sv
`ifndef DIFFERENTIAL_DRIVE_STEERING_TOP_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_STEERING_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define DDS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dds assertion failed");

// next-cycle implication, off during reset
`define DDS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dds assertion failed");

// next-cycle implication, always checked
`define DDS_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("dds assertion failed");

`endif

// ----- hdl/dds_pkg.sv -----
// ----------------------------------------------------------------------------
// dds_pkg
// Shared constants and the arctangent table for the steering pipeline.
// ----------------------------------------------------------------------------
package dds_pkg;

   localparam int CORDIC_STAGES_DEFAULT = 16;
   localparam int MAX_STAGES = 24;

   // 1/K in Q.30
   localparam logic [29:0] INV_GAIN = 30'd652032874;

   localparam logic [15:0] GAIN_RESET = 16'd256;

   localparam logic REG_VELOCITY_GAIN = 1'b0;
   localparam logic REG_TURNING_GAIN  = 1'b1;

   localparam logic signed [15:0] QUARTER_TURN = 16'sd16384;

   // atan(2^-i) as a 32-bit binary angle
   function automatic logic [31:0] atan_f(input int i);
      logic [31:0] r;
      case (i)
         0:       r = 32'h20000000;
         1:       r = 32'h12E4051E;
         2:       r = 32'h09FB385B;
         3:       r = 32'h051111D4;
         4:       r = 32'h028B0D43;
         5:       r = 32'h0145D7E1;
         6:       r = 32'h00A2F61E;
         7:       r = 32'h00517C55;
         8:       r = 32'h0028BE53;
         9:       r = 32'h00145F2F;
         10:      r = 32'h000A2F98;
         11:      r = 32'h000517CC;
         12:      r = 32'h00028BE6;
         13:      r = 32'h000145F3;
         14:      r = 32'h0000A2FA;
         15:      r = 32'h0000517D;
         16:      r = 32'h000028BE;
         17:      r = 32'h0000145F;
         18:      r = 32'h00000A30;
         19:      r = 32'h00000518;
         20:      r = 32'h0000028C;
         21:      r = 32'h00000146;
         22:      r = 32'h000000A3;
         23:      r = 32'h00000051;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

endpackage

// ----- hdl/differential_drive_steering_top.sv -----
// ----------------------------------------------------------------------------
// differential_drive_steering_top
// Wheel speeds of a differential drive from a wanted direction and heading.
// ----------------------------------------------------------------------------
//   channel | ports                                   | direction
//   req     | req_valid req_stall dir_x dir_y heading | in
//   rsp     | rsp_valid rsp_stall left/right_speed    | out
//   csr     | csr_we csr_index csr_wdata              | in
//
// one request per cycle unless a result stalls; N = min(CORDIC_STAGES, 24) is
// each CORDIC's iteration count; there are eight multiply and rounding stages.
// reset is synchronous and clears all valid bits; gains return to 1.0.
// a stalled result freezes the whole pipeline, req_stall follows it.
// ----------------------------------------------------------------------------
module differential_drive_steering_top
   import dds_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_dir_x,
   input  logic signed [15:0] req_dir_y,
   input  logic signed [15:0] req_heading,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [19:0] rsp_left_speed,
   output logic signed [19:0] rsp_right_speed,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [15:0]        csr_wdata
);

   logic        en;
   logic [15:0] vel_gain_ff;
   logic [15:0] turn_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vel_gain_ff  <= GAIN_RESET;
         turn_gain_ff <= GAIN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_VELOCITY_GAIN: vel_gain_ff  <= csr_wdata;
            REG_TURNING_GAIN:  turn_gain_ff <= csr_wdata;
            default:           vel_gain_ff  <= vel_gain_ff;
         endcase
      end
   end

   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   // vectoring
   logic               vec_valid;
   logic signed [35:0] vec_x;
   logic [31:0]        vec_ang;
   logic [15:0]        vec_head;

   dds_cordic_vec #(
      .STAGES (CORDIC_STAGES),
      .SIDE_W (16)
   ) u_vec (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .dir_x     (req_dir_x),
      .dir_y     (req_dir_y),
      .side_in   (req_heading),
      .out_valid (vec_valid),
      .x_out     (vec_x),
      .ang_out   (vec_ang),
      .side_out  (vec_head)
   );

   // stage a: length partial products, heading error
   logic               a_valid_ff;
   logic [46:0]        a_pp_lo_ff, a_pp_hi_ff;
   logic signed [15:0] a_err_ff;
   logic               a_wide_ff;
   logic [46:0]        a_pp_lo_in, a_pp_hi_in;
   logic signed [15:0] a_err_in;
   logic               a_wide_in;

   always_comb begin
      logic [31:0] ang_r;
      ang_r      = vec_ang + 32'h00008000;
      a_pp_lo_in = 47'(vec_x[16:0]) * 47'(INV_GAIN);
      a_pp_hi_in = 47'(vec_x[33:17]) * 47'(INV_GAIN);
      a_err_in   = $signed(ang_r[31:16] - vec_head);
      a_wide_in  = (a_err_in >= QUARTER_TURN) || (a_err_in <= -QUARTER_TURN);
   end

   // stage b: length in Q.8
   logic               b_valid_ff;
   logic [25:0]        b_len_ff;
   logic signed [15:0] b_err_ff;
   logic               b_wide_ff;
   logic [25:0]        b_len_in;

   always_comb begin
      logic [63:0] prod;
      prod     = ({17'd0, a_pp_hi_ff} << 17) + {17'd0, a_pp_lo_ff} + (64'd1 << 37);
      b_len_in = prod[63:38];
   end

   // stage c: forward speed
   logic               c_valid_ff;
   logic [32:0]        c_vel_ff;
   logic signed [15:0] c_err_ff;
   logic               c_wide_ff;
   logic [32:0]        c_vel_in;

   always_comb begin
      logic [41:0] sum;
      sum      = 42'(b_len_ff) * 42'(vel_gain_ff) + 42'd128;
      c_vel_in = sum[40:8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= vec_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
      if (en) begin
         a_pp_lo_ff <= a_pp_lo_in;
         a_pp_hi_ff <= a_pp_hi_in;
         a_err_ff   <= a_err_in;
         a_wide_ff  <= a_wide_in;
         b_len_ff   <= b_len_in;
         b_err_ff   <= a_err_ff;
         b_wide_ff  <= a_wide_ff;
         c_vel_ff   <= c_vel_in;
         c_err_ff   <= b_err_ff;
         c_wide_ff  <= b_wide_ff;
      end
   end

   // rotation
   logic               rot_valid;
   logic signed [33:0] rot_c, rot_s;
   logic               rot_flip;
   logic [33:0]        rot_side;

   dds_cordic_rot #(
      .STAGES (CORDIC_STAGES),
      .SIDE_W (34)
   ) u_rot (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (c_valid_ff),
      .err       (c_err_ff),
      .side_in   ({c_vel_ff, c_wide_ff}),
      .out_valid (rot_valid),
      .cos_out   (rot_c),
      .sin_out   (rot_s),
      .flip_out  (rot_flip),
      .side_out  (rot_side)
   );

   // stage d: fold back and round to Q.15
   logic               d_valid_ff;
   logic signed [17:0] d_c15_ff, d_s15_ff;
   logic [32:0]        d_vel_ff;
   logic               d_wide_ff;
   logic signed [17:0] d_c15_in, d_s15_in;

   always_comb begin
      logic signed [33:0] c;
      logic signed [33:0] s;
      logic signed [33:0] cr;
      logic signed [33:0] sr;
      c        = rot_flip ? -rot_c : rot_c;
      s        = rot_flip ? -rot_s : rot_s;
      cr       = (c + 34'sd16384) >>> 15;
      sr       = (s + 34'sd16384) >>> 15;
      d_c15_in = cr[17:0];
      d_s15_in = sr[17:0];
   end

   // stage e: turning gain on sine
   logic               e_valid_ff;
   logic signed [34:0] e_ts_ff;
   logic signed [17:0] e_c15_ff;
   logic [32:0]        e_vel_ff;
   logic               e_wide_ff;
   logic signed [34:0] e_ts_in;

   assign e_ts_in = d_s15_ff * $signed({1'b0, turn_gain_ff});

   // stage f: split products of speed
   logic               f_valid_ff;
   logic signed [34:0] f_pf_lo_ff;
   logic signed [35:0] f_pf_hi_ff;
   logic signed [51:0] f_pt_lo_ff;
   logic signed [52:0] f_pt_hi_ff;
   logic               f_wide_ff;
   logic signed [34:0] f_pf_lo_in;
   logic signed [35:0] f_pf_hi_in;
   logic signed [51:0] f_pt_lo_in;
   logic signed [52:0] f_pt_hi_in;

   assign f_pf_lo_in = $signed({1'b0, e_vel_ff[15:0]}) * e_c15_ff;
   assign f_pf_hi_in = $signed({1'b0, e_vel_ff[32:16]}) * e_c15_ff;
   assign f_pt_lo_in = $signed({1'b0, e_vel_ff[15:0]}) * e_ts_ff;
   assign f_pt_hi_in = $signed({1'b0, e_vel_ff[32:16]}) * e_ts_ff;

   // stage g: forward and turn terms in Q.31
   logic               g_valid_ff;
   logic signed [71:0] g_fwd_ff, g_turn_ff;
   logic               g_wide_ff;
   logic signed [71:0] g_fwd_in, g_turn_in;

   assign g_fwd_in  = (72'(f_pf_hi_ff) <<< 24) + (72'(f_pf_lo_ff) <<< 8);
   assign g_turn_in = (72'(f_pt_hi_ff) <<< 16) + 72'(f_pt_lo_ff);

   // stage h: mix, round to Q.0, saturate
   logic               rsp_valid_ff;
   logic signed [19:0] left_ff, right_ff;
   logic signed [19:0] left_in, right_in;

   function automatic logic signed [19:0] round_sat(input logic signed [71:0] v);
      logic signed [71:0] r;
      logic signed [19:0] o;
      r = (v + 72'sh40000000) >>> 31;
      if (r > 72'sd524287) begin
         o = 20'sh7FFFF;
      end else if (r < -72'sd524288) begin
         o = 20'sh80000;
      end else begin
         o = r[19:0];
      end
      return o;
   endfunction

   always_comb begin
      if (g_wide_ff) begin
         left_in  = round_sat(g_fwd_ff + g_turn_ff);
         right_in = round_sat(g_fwd_ff - g_turn_ff);
      end else begin
         left_in  = round_sat(g_fwd_ff - g_turn_ff);
         right_in = round_sat(g_fwd_ff + g_turn_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff   <= 1'b0;
         e_valid_ff   <= 1'b0;
         f_valid_ff   <= 1'b0;
         g_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         d_valid_ff   <= rot_valid;
         e_valid_ff   <= d_valid_ff;
         f_valid_ff   <= e_valid_ff;
         g_valid_ff   <= f_valid_ff;
         rsp_valid_ff <= g_valid_ff;
      end
      if (en) begin
         d_c15_ff   <= d_c15_in;
         d_s15_ff   <= d_s15_in;
         d_vel_ff   <= rot_side[33:1];
         d_wide_ff  <= rot_side[0];
         e_ts_ff    <= e_ts_in;
         e_c15_ff   <= d_c15_ff;
         e_vel_ff   <= d_vel_ff;
         e_wide_ff  <= d_wide_ff;
         f_pf_lo_ff <= f_pf_lo_in;
         f_pf_hi_ff <= f_pf_hi_in;
         f_pt_lo_ff <= f_pt_lo_in;
         f_pt_hi_ff <= f_pt_hi_in;
         f_wide_ff  <= e_wide_ff;
         g_fwd_ff   <= g_fwd_in;
         g_turn_ff  <= g_turn_in;
         g_wide_ff  <= f_wide_ff;
         left_ff    <= left_in;
         right_ff   <= right_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_speed  = left_ff;
   assign rsp_right_speed = right_ff;

endmodule

// ----- hdl/dds_cordic_vec.sv -----
// ----------------------------------------------------------------------------
// dds_cordic_vec
// Pipelined vectoring CORDIC: length (scaled by K) and angle of a vector.
// ----------------------------------------------------------------------------
module dds_cordic_vec
   import dds_pkg::*;
#(
   parameter int STAGES = CORDIC_STAGES_DEFAULT,
   parameter int SIDE_W = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic signed [15:0]       dir_x,
   input  logic signed [15:0]       dir_y,
   input  logic [SIDE_W-1:0]        side_in,
   output logic                     out_valid,
   output logic signed [35:0]       x_out,
   output logic [31:0]              ang_out,
   output logic [SIDE_W-1:0]        side_out
);

   localparam int N = (STAGES > MAX_STAGES) ? MAX_STAGES : STAGES;

   logic               valid_ff [0:N];
   logic signed [35:0] x_ff     [0:N];
   logic signed [35:0] y_ff     [0:N];
   logic [31:0]        ang_ff   [0:N];
   logic [SIDE_W-1:0]  side_ff  [0:N];
   logic signed [35:0] x_in     [0:N];
   logic signed [35:0] y_in     [0:N];
   logic [31:0]        ang_in   [0:N];

   // left half plane is turned by pi first
   always_comb begin
      logic signed [35:0] xs;
      logic signed [35:0] ys;
      xs = 36'(dir_x) <<< 16;
      ys = 36'(dir_y) <<< 16;
      if (dir_x[15]) begin
         x_in[0]   = -xs;
         y_in[0]   = -ys;
         ang_in[0] = 32'h80000000;
      end else begin
         x_in[0]   = xs;
         y_in[0]   = ys;
         ang_in[0] = 32'h00000000;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
      if (en) begin
         x_ff[0]    <= x_in[0];
         y_ff[0]    <= y_in[0];
         ang_ff[0]  <= ang_in[0];
         side_ff[0] <= side_in;
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_stage
      always_comb begin
         if (!y_ff[k][35]) begin
            x_in[k+1]   = x_ff[k] + (y_ff[k] >>> k);
            y_in[k+1]   = y_ff[k] - (x_ff[k] >>> k);
            ang_in[k+1] = ang_ff[k] + atan_f(k);
         end else begin
            x_in[k+1]   = x_ff[k] - (y_ff[k] >>> k);
            y_in[k+1]   = y_ff[k] + (x_ff[k] >>> k);
            ang_in[k+1] = ang_ff[k] - atan_f(k);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            valid_ff[k+1] <= valid_ff[k];
         end
         if (en) begin
            x_ff[k+1]    <= x_in[k+1];
            y_ff[k+1]    <= y_in[k+1];
            ang_ff[k+1]  <= ang_in[k+1];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = valid_ff[N];
   assign x_out     = x_ff[N];
   assign ang_out   = ang_ff[N];
   assign side_out  = side_ff[N];

endmodule

// ----- hdl/dds_cordic_rot.sv -----
// ----------------------------------------------------------------------------
// dds_cordic_rot
// Pipelined rotation CORDIC: cos and sin (Q.30) of a 16-bit binary angle.
// ----------------------------------------------------------------------------
module dds_cordic_rot
   import dds_pkg::*;
#(
   parameter int STAGES = CORDIC_STAGES_DEFAULT,
   parameter int SIDE_W = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic signed [15:0]       err,
   input  logic [SIDE_W-1:0]        side_in,
   output logic                     out_valid,
   output logic signed [33:0]       cos_out,
   output logic signed [33:0]       sin_out,
   output logic                     flip_out,
   output logic [SIDE_W-1:0]        side_out
);

   localparam int N = (STAGES > MAX_STAGES) ? MAX_STAGES : STAGES;

   logic               valid_ff [0:N];
   logic               flip_ff  [0:N];
   logic signed [33:0] c_ff     [0:N];
   logic signed [33:0] s_ff     [0:N];
   logic signed [33:0] z_ff     [0:N];
   logic [SIDE_W-1:0]  side_ff  [0:N];
   logic signed [33:0] c_in     [0:N];
   logic signed [33:0] s_in     [0:N];
   logic signed [33:0] z_in     [0:N];
   logic               flip_in;

   // angles beyond a quarter turn are folded by pi and the result negated
   always_comb begin
      logic signed [33:0] z0;
      z0 = 34'(err) <<< 16;
      c_in[0] = $signed({4'b0000, INV_GAIN});
      s_in[0] = 34'sd0;
      if (z0 > 34'sh40000000) begin
         z_in[0] = z0 - 34'sh80000000;
         flip_in = 1'b1;
      end else if (z0 < -34'sh40000000) begin
         z_in[0] = z0 + 34'sh80000000;
         flip_in = 1'b1;
      end else begin
         z_in[0] = z0;
         flip_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
      if (en) begin
         c_ff[0]    <= c_in[0];
         s_ff[0]    <= s_in[0];
         z_ff[0]    <= z_in[0];
         flip_ff[0] <= flip_in;
         side_ff[0] <= side_in;
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_stage
      always_comb begin
         if (!z_ff[k][33]) begin
            c_in[k+1] = c_ff[k] - (s_ff[k] >>> k);
            s_in[k+1] = s_ff[k] + (c_ff[k] >>> k);
            z_in[k+1] = z_ff[k] - $signed({2'b00, atan_f(k)});
         end else begin
            c_in[k+1] = c_ff[k] + (s_ff[k] >>> k);
            s_in[k+1] = s_ff[k] - (c_ff[k] >>> k);
            z_in[k+1] = z_ff[k] + $signed({2'b00, atan_f(k)});
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            valid_ff[k+1] <= valid_ff[k];
         end
         if (en) begin
            c_ff[k+1]    <= c_in[k+1];
            s_ff[k+1]    <= s_in[k+1];
            z_ff[k+1]    <= z_in[k+1];
            flip_ff[k+1] <= flip_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = valid_ff[N];
   assign cos_out   = c_ff[N];
   assign sin_out   = s_ff[N];
   assign flip_out  = flip_ff[N];
   assign side_out  = side_ff[N];

endmodule

// ----- hdl/dds_checker.sv -----
// ----------------------------------------------------------------------------
// dds_checker
// Port-level checks on the steering block, bound to the top level.
// ----------------------------------------------------------------------------
`include "differential_drive_steering_top_assert.svh"

module dds_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [19:0] rsp_left_speed,
   input logic signed [19:0] rsp_right_speed
);

   logic [39:0] rsp_data;

   assign rsp_data = {rsp_left_speed, rsp_right_speed};

   // pipeline is empty right after reset
   `DDS_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

   // requests are held back only behind a stalled result
   `DDS_ASSERT_IMPL(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   `DDS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   `DDS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data))

endmodule

bind differential_drive_steering_top dds_checker u_dds_checker (.*);
